### rtl/quadratic_bezier_rasterizer_macros.svh
// Assertion macros shared by the checker of the quadratic Bezier rasterizer.
`ifndef QUADRATIC_BEZIER_RASTERIZER_MACROS_SVH
`define QUADRATIC_BEZIER_RASTERIZER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QBR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define QBR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/qbr_pkg.sv
// Types and constants shared by the quadratic Bezier rasterizer modules.
package qbr_pkg;

  localparam int CoordXW = 9;
  localparam int CoordYW = 8;
  localparam int StepW   = 6;
  localparam int NsqW    = 12;
  localparam int DdW     = 12;
  localparam int AccW    = 23;
  localparam int MagW    = 21;
  localparam int DshW    = 18;
  localparam int AddrW   = 20;
  localparam int PitchW  = 12;
  localparam int ColourW = 8;
  localparam int CfgIdxW = 1;

  localparam logic [ColourW-1:0] COLOUR_CURVE = 8'd15;
  localparam logic [ColourW-1:0] COLOUR_MARK  = 8'd1;

  localparam logic [CfgIdxW-1:0] CFG_FRAME_BASE = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_ROW_PITCH  = 1'd1;

  localparam logic [AddrW-1:0]  FRAME_BASE_RESET = 20'hA0000;
  localparam logic [PitchW-1:0] ROW_PITCH_RESET  = 12'd320;

  typedef struct packed {
    logic [CoordXW-1:0]     x1;
    logic [CoordYW-1:0]     y1;
    logic [CoordXW-1:0]     x2;
    logic [CoordYW-1:0]     y2;
    logic [CoordXW-1:0]     x3;
    logic [CoordYW-1:0]     y3;
    logic [StepW-1:0]       n;
    logic                   no_samples;
    logic [NsqW-1:0]        nsq;
    logic signed [DdW-1:0]  ddx;
    logic signed [DdW-1:0]  ddy;
    logic signed [AccW-1:0] dx0;
    logic signed [AccW-1:0] dy0;
  } curve_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_PIX,
    BK_MARK_A,
    BK_MARK_B,
    BK_MARK_C
  } bk_state_t;

endpackage

### rtl/qbr_fifo.sv
// Short queue of prepared curve requests between the front and back ends.
module qbr_fifo import qbr_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  curve_rec_t wdata,
  input  logic       pop,
  output curve_rec_t rdata,
  output q_status_t  status
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  curve_rec_t          mem [DEPTH];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     rd_ptr;
  logic [CntW-1:0]     count;

  assign rdata        = mem[rd_ptr];
  assign status.full  = (count == CntW'(DEPTH));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/qbr_front.sv
// Front end: accepts curve requests and prepares the forward-difference terms.
module qbr_front import qbr_pkg::*; #(
  parameter int MAX_STEPS = 61
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  logic [CoordXW-1:0] ax,
  input  logic [CoordYW-1:0] ay,
  input  logic [CoordXW-1:0] bx,
  input  logic [CoordYW-1:0] by_coord,
  input  logic [CoordXW-1:0] cx,
  input  logic [CoordYW-1:0] cy,
  input  logic [StepW-1:0]   step_count,
  input  q_status_t          q_st,
  output logic               q_push,
  output curve_rec_t         q_wdata
);

  logic               h_valid;
  logic [CoordXW-1:0] h_ax;
  logic [CoordYW-1:0] h_ay;
  logic [CoordXW-1:0] h_bx;
  logic [CoordYW-1:0] h_by;
  logic [CoordXW-1:0] h_cx;
  logic [CoordYW-1:0] h_cy;
  logic [StepW-1:0]   h_n;

  logic [StepW-1:0]       n_sat;
  logic                   accept;
  logic signed [9:0]      ex1;
  logic signed [9:0]      ex2;
  logic signed [8:0]      ey1;
  logic signed [8:0]      ey2;
  logic signed [10:0]     dex;
  logic signed [10:0]     dey;
  logic [StepW:0]         odd;
  logic signed [17:0]     prod_x;
  logic signed [16:0]     prod_y;

  assign n_sat     = (step_count > StepW'(MAX_STEPS)) ? StepW'(MAX_STEPS) : step_count;
  assign cmd_stall = h_valid && q_st.full;
  assign accept    = cmd_valid && !cmd_stall;
  assign q_push    = h_valid && !q_st.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid <= 1'b0;
    end else if (accept) begin
      h_valid <= 1'b1;
    end else if (q_push) begin
      h_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      h_ax <= ax;
      h_ay <= ay;
      h_bx <= bx;
      h_by <= by_coord;
      h_cx <= cx;
      h_cy <= cy;
      h_n  <= n_sat;
    end
  end

  assign ex1    = $signed({1'b0, h_bx}) - $signed({1'b0, h_ax});
  assign ex2    = $signed({1'b0, h_cx}) - $signed({1'b0, h_bx});
  assign ey1    = $signed({1'b0, h_by}) - $signed({1'b0, h_ay});
  assign ey2    = $signed({1'b0, h_cy}) - $signed({1'b0, h_by});
  assign dex    = 11'(ex2) - 11'(ex1);
  assign dey    = 11'(ey2) - 11'(ey1);
  assign odd    = {h_n, 1'b0} - 1'b1;
  assign prod_x = ex1 * $signed({1'b0, odd});
  assign prod_y = ey1 * $signed({1'b0, odd});

  always_comb begin
    q_wdata.x1         = h_ax;
    q_wdata.y1         = h_ay;
    q_wdata.x2         = h_bx;
    q_wdata.y2         = h_by;
    q_wdata.x3         = h_cx;
    q_wdata.y3         = h_cy;
    q_wdata.n          = h_n;
    q_wdata.no_samples = (h_n == '0);
    q_wdata.nsq        = NsqW'(h_n) * NsqW'(h_n);
    q_wdata.ddx        = {dex, 1'b0};
    q_wdata.ddy        = DdW'({dey, 1'b0});
    q_wdata.dx0        = AccW'(prod_x) + AccW'(ex2);
    q_wdata.dy0        = AccW'(prod_y) + AccW'(ey2);
  end

endmodule

### rtl/qbr_back.sv
// Back end: steps the curve, divides by the squared step count and writes pixels.
module qbr_back import qbr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  q_status_t          q_st,
  input  curve_rec_t         q_rdata,
  output logic               q_pop,
  input  logic [AddrW-1:0]   frame_base,
  input  logic [PitchW-1:0]  row_pitch,
  output logic               pix_valid,
  input  logic               pix_stall,
  output logic [AddrW-1:0]   pixel_address,
  output logic [ColourW-1:0] pixel_colour,
  output logic               last_write
);

  bk_state_t              state;
  bk_state_t              state_next;
  curve_rec_t             rec;
  logic signed [AccW-1:0] acc_x;
  logic signed [AccW-1:0] acc_y;
  logic signed [AccW-1:0] delta_x;
  logic signed [AccW-1:0] delta_y;
  logic [StepW-1:0]       step_index;
  logic [MagW-1:0]        rem_x;
  logic [MagW-1:0]        rem_y;
  logic                   neg_x;
  logic                   neg_y;
  logic [DshW-1:0]        dsh;
  logic [CoordXW-1:0]     qx;
  logic [CoordXW-1:0]     qy;
  logic [1:0]             div_cnt;

  logic                   out_free;
  logic                   emit;
  logic [MagW+2:0]        step_x;
  logic [MagW+2:0]        step_y;
  logic signed [AccW-1:0] acc_nx;
  logic signed [AccW-1:0] acc_ny;
  logic [CoordXW-1:0]     px;
  logic [CoordYW-1:0]     py;
  logic [CoordXW-1:0]     sel_x;
  logic [CoordYW-1:0]     sel_y;
  logic [AddrW-1:0]       row_off;
  logic [AddrW-1:0]       addr;

  // Three restoring quotient bits per call, most significant first.
  function automatic logic [MagW+2:0] div3(input logic [MagW-1:0] rem,
                                           input logic [DshW-1:0] d);
    logic [MagW-1:0] r;
    logic [2:0]      q;
    logic [MagW-1:0] t2;
    logic [MagW-1:0] t1;
    logic [MagW-1:0] t0;
    r  = rem;
    t2 = MagW'({d, 2'b00});
    t1 = MagW'({d, 1'b0});
    t0 = MagW'(d);
    q  = '0;
    if (r >= t2) begin
      r    = r - t2;
      q[2] = 1'b1;
    end
    if (r >= t1) begin
      r    = r - t1;
      q[1] = 1'b1;
    end
    if (r >= t0) begin
      r    = r - t0;
      q[0] = 1'b1;
    end
    return {r, q};
  endfunction

  assign step_x  = div3(rem_x, dsh);
  assign step_y  = div3(rem_y, dsh);
  assign acc_nx  = acc_x + delta_x;
  assign acc_ny  = acc_y + delta_y;
  assign px      = rec.x1 + (neg_x ? (~qx + 1'b1) : qx);
  assign py      = rec.y1 + CoordYW'(neg_y ? (~qy + 1'b1) : qy);
  assign row_off = AddrW'(sel_y) * AddrW'(row_pitch);
  assign addr    = frame_base + row_off + AddrW'(sel_x);

  always_comb begin
    out_free   = !pix_valid || !pix_stall;
    state_next = state;
    q_pop      = 1'b0;
    emit       = 1'b0;
    sel_x      = px;
    sel_y      = py;
    case (state)
      BK_IDLE: begin
        if (!q_st.empty) begin
          q_pop      = 1'b1;
          state_next = q_rdata.no_samples ? BK_MARK_A : BK_DIV;
        end
      end
      BK_DIV: begin
        if (div_cnt == 2'd2) begin
          state_next = BK_PIX;
        end
      end
      BK_PIX: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = ((step_index + 1'b1) == rec.n) ? BK_MARK_A : BK_DIV;
        end
      end
      BK_MARK_A: begin
        sel_x = rec.x1;
        sel_y = rec.y1;
        if (out_free) begin
          emit       = 1'b1;
          state_next = BK_MARK_B;
        end
      end
      BK_MARK_B: begin
        sel_x = rec.x2;
        sel_y = rec.y2;
        if (out_free) begin
          emit       = 1'b1;
          state_next = BK_MARK_C;
        end
      end
      BK_MARK_C: begin
        sel_x = rec.x3;
        sel_y = rec.y3;
        if (out_free) begin
          emit       = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      pix_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        pix_valid <= 1'b1;
      end else if (!pix_stall) begin
        pix_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pixel_address <= addr;
      pixel_colour  <= (state == BK_PIX) ? COLOUR_CURVE : COLOUR_MARK;
      last_write    <= (state == BK_MARK_C);
    end
    case (state)
      BK_IDLE: begin
        if (q_pop) begin
          rec        <= q_rdata;
          acc_x      <= '0;
          acc_y      <= '0;
          delta_x    <= q_rdata.dx0;
          delta_y    <= q_rdata.dy0;
          step_index <= '0;
          rem_x      <= '0;
          rem_y      <= '0;
          neg_x      <= 1'b0;
          neg_y      <= 1'b0;
          dsh        <= {q_rdata.nsq, 6'b0};
          div_cnt    <= '0;
        end
      end
      BK_DIV: begin
        rem_x   <= step_x[MagW+2:3];
        rem_y   <= step_y[MagW+2:3];
        qx      <= {qx[CoordXW-4:0], step_x[2:0]};
        qy      <= {qy[CoordXW-4:0], step_y[2:0]};
        dsh     <= dsh >> 3;
        div_cnt <= div_cnt + 1'b1;
      end
      BK_PIX: begin
        if (emit) begin
          acc_x      <= acc_nx;
          acc_y      <= acc_ny;
          delta_x    <= delta_x + AccW'(rec.ddx);
          delta_y    <= delta_y + AccW'(rec.ddy);
          step_index <= step_index + 1'b1;
          neg_x      <= acc_nx[AccW-1];
          neg_y      <= acc_ny[AccW-1];
          rem_x      <= acc_nx[AccW-1] ? MagW'(-acc_nx) : acc_nx[MagW-1:0];
          rem_y      <= acc_ny[AccW-1] ? MagW'(-acc_ny) : acc_ny[MagW-1:0];
          dsh        <= {rec.nsq, 6'b0};
          div_cnt    <= '0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/quadratic_bezier_rasterizer.sv
// Top level of the quadratic Bezier rasterizer.
//
// Each request on the command channel (cmd_valid, cmd_stall) carries three
// control points and a step count; counts above MAX_STEPS are clamped.
// For every sample the pixel channel (pix_valid, pix_stall) delivers one
// frame buffer write of colour 15, followed by colour 1 writes that mark
// the first, middle and end control points; the end marker has last_write.
// The front end registers a request and works out the difference terms,
// then hands it through a queue of QUEUE_DEPTH entries to the back end, so
// a new request can be taken while an earlier curve is still being drawn.
// For each sample the x and y dividers resolve three quotient bits per cycle
// in BK_DIV until the quotient is complete, then BK_PIX issues the write.
// The markers are then written from BK_MARK_A, BK_MARK_B and BK_MARK_C.
// When the receiver stalls, the output register holds its write and the
// back end waits; the queue then fills and cmd_stall is raised.
// Reset empties the queue and restores frame_base to 0xA0000 and row_pitch
// to 320; configuration writes take effect at once. The user must make them
// only while idle; the block itself does not enforce it.
module quadratic_bezier_rasterizer import qbr_pkg::*; #(
  parameter int MAX_STEPS   = 61,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [AddrW-1:0]   cfg_data,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  logic [CoordXW-1:0] ax,
  input  logic [CoordYW-1:0] ay,
  input  logic [CoordXW-1:0] bx,
  input  logic [CoordYW-1:0] by_coord,
  input  logic [CoordXW-1:0] cx,
  input  logic [CoordYW-1:0] cy,
  input  logic [StepW-1:0]   step_count,
  output logic               pix_valid,
  input  logic               pix_stall,
  output logic [AddrW-1:0]   pixel_address,
  output logic [ColourW-1:0] pixel_colour,
  output logic               last_write
);

  logic [AddrW-1:0]  frame_base;
  logic [PitchW-1:0] row_pitch;
  q_status_t         q_st;
  logic              q_push;
  logic              q_pop;
  curve_rec_t        q_wdata;
  curve_rec_t        q_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_base <= FRAME_BASE_RESET;
      row_pitch  <= ROW_PITCH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_FRAME_BASE: frame_base <= cfg_data;
        CFG_ROW_PITCH:  row_pitch  <= cfg_data[PitchW-1:0];
        default: begin
        end
      endcase
    end
  end

  qbr_front #(
    .MAX_STEPS(MAX_STEPS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .ax        (ax),
    .ay        (ay),
    .bx        (bx),
    .by_coord  (by_coord),
    .cx        (cx),
    .cy        (cy),
    .step_count(step_count),
    .q_st      (q_st),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  qbr_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .status(q_st)
  );

  qbr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_st         (q_st),
    .q_rdata      (q_rdata),
    .q_pop        (q_pop),
    .frame_base   (frame_base),
    .row_pitch    (row_pitch),
    .pix_valid    (pix_valid),
    .pix_stall    (pix_stall),
    .pixel_address(pixel_address),
    .pixel_colour (pixel_colour),
    .last_write   (last_write)
  );

endmodule

### rtl/qbr_checker.sv
// Port-level checks on the pixel channel of the quadratic Bezier rasterizer.
`include "quadratic_bezier_rasterizer_macros.svh"

module qbr_checker import qbr_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               pix_valid,
  input logic               pix_stall,
  input logic [AddrW-1:0]   pixel_address,
  input logic [ColourW-1:0] pixel_colour,
  input logic               last_write
);

  `QBR_ASSERT_NEXT(a_stall_hold, clk, rst, pix_valid && pix_stall,
    pix_valid && $stable(pixel_address) && $stable(pixel_colour) && $stable(last_write),
    "stalled pixel write changed")
  `QBR_ASSERT_SAME(a_colour_known, clk, rst, pix_valid,
    pixel_colour == COLOUR_CURVE || pixel_colour == COLOUR_MARK, "unexpected pixel colour")
  `QBR_ASSERT_SAME(a_last_is_marker, clk, rst, pix_valid && last_write,
    pixel_colour == COLOUR_MARK, "last write is not a marker")
  `QBR_ASSERT_SAME(a_quiet_after_reset, clk, rst, $past(rst), !pix_valid,
    "pixel write straight after reset")

endmodule

bind quadratic_bezier_rasterizer qbr_checker u_qbr_checker (
  .clk          (clk),
  .rst          (rst),
  .pix_valid    (pix_valid),
  .pix_stall    (pix_stall),
  .pixel_address(pixel_address),
  .pixel_colour (pixel_colour),
  .last_write   (last_write)
);
